### hw/rtl/spt_pkg.sv
// Shared types, sizes and command codes for the sparse polynomial term table.
`default_nettype none
package spt_pkg;

    localparam int MAX_TERMS = 16;
    localparam int IDX_W     = $clog2(MAX_TERMS);
    localparam int CNT_W     = $clog2(MAX_TERMS + 1);
    localparam int COEF_W    = 32;
    localparam int EXP_W     = 8;
    localparam int DEG_W     = 9;
    localparam int TCNT_W    = 5;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 56;

    typedef enum logic [1:0] {
        CMD_ADD  = 2'd0,
        CMD_SET  = 2'd1,
        CMD_DIFF = 2'd2,
        CMD_READ = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_MISSING = 2'd1,
        STAT_FULL    = 2'd2
    } status_t;

    typedef struct packed {
        logic              valid;
        logic [COEF_W-1:0] coef;
        logic [EXP_W-1:0]  exp;
    } entry_t;

    typedef struct packed {
        cmd_t              cmd;
        logic              insert;
        logic              placed;
        logic [COEF_W-1:0] coef;
        logic [EXP_W-1:0]  exp;
    } head_ctl_t;

    typedef struct packed {
        logic match;
        logic sat;
        logic place;
    } head_res_t;

endpackage
`default_nettype wire

### hw/rtl/spt_cell.sv
// One storage cell of the rotating term chain.
`default_nettype none
module spt_cell
    import spt_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   shift_en,
    input  wire entry_t din,
    output entry_t      dout
);

    logic              valid_reg;
    logic [COEF_W-1:0] coef_reg;
    logic [EXP_W-1:0]  exp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (shift_en) begin
            valid_reg <= din.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            coef_reg <= din.coef;
            exp_reg  <= din.exp;
        end
    end

    assign dout = '{valid: valid_reg, coef: coef_reg, exp: exp_reg};

endmodule
`default_nettype wire

### hw/rtl/spt_head.sv
// Term processor at the head of the chain: updates the one entry passing by.
`default_nettype none
module spt_head
    import spt_pkg::*;
(
    input  wire head_ctl_t ctl,
    input  wire entry_t    din,
    output entry_t         dout,
    output head_res_t      res
);

    localparam logic [COEF_W-1:0] COEF_POS = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0] COEF_NEG = {1'b1, {(COEF_W-1){1'b0}}};

    logic signed [COEF_W:0]         sum;
    logic signed [COEF_W+EXP_W:0]   prod;
    logic                           sum_ovf;
    logic                           prod_ovf;
    logic [COEF_W-1:0]              sum_sat;
    logic [COEF_W-1:0]              prod_sat;

    assign sum  = $signed({din.coef[COEF_W-1], din.coef})
                + $signed({ctl.coef[COEF_W-1], ctl.coef});
    assign prod = $signed(din.coef) * $signed({1'b0, din.exp});

    assign sum_ovf  = sum[COEF_W] != sum[COEF_W-1];
    // The product fits when every bit above the sign position equals the sign.
    assign prod_ovf = !((&prod[COEF_W+EXP_W:COEF_W-1]) || !(|prod[COEF_W+EXP_W:COEF_W-1]));
    assign sum_sat  = sum_ovf  ? (sum[COEF_W] ? COEF_NEG : COEF_POS) : sum[COEF_W-1:0];
    assign prod_sat = prod_ovf ? (prod[COEF_W+EXP_W] ? COEF_NEG : COEF_POS)
                               : prod[COEF_W-1:0];

    always_comb begin
        dout = din;
        res  = '0;
        if (ctl.insert) begin
            if (!din.valid && !ctl.placed) begin
                dout.valid = 1'b1;
                dout.coef  = ctl.coef;
                dout.exp   = ctl.exp;
                res.place  = 1'b1;
            end
        end else if (ctl.cmd == CMD_DIFF) begin
            if (din.valid) begin
                if (din.exp == '0) begin
                    dout.valid = 1'b0;
                end else begin
                    dout.coef = prod_sat;
                    dout.exp  = din.exp - 1'b1;
                    res.sat   = prod_ovf;
                end
            end
        end else if (din.valid && din.exp == ctl.exp) begin
            res.match = 1'b1;
            case (ctl.cmd)
                CMD_ADD: begin
                    dout.coef = sum_sat;
                    res.sat   = sum_ovf;
                    if (sum_sat == '0) begin
                        dout.valid = 1'b0;
                    end
                end
                CMD_SET: begin
                    dout.coef = ctl.coef;
                    if (ctl.coef == '0) begin
                        dout.valid = 1'b0;
                    end
                end
                default: begin
                    dout = din;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### hw/rtl/sparse_polynomial_term_table.sv
// A command runs a scan pass (ST_SCAN), plus an insert pass (ST_INSERT) for an append, then ST_DONE;
// each pass rotates the chain of MAX_TERMS cells once through the head processor. The next command
// is taken only after ST_DONE has loaded the result beat, and ST_DONE waits while the output is held.
// A new command is taken while the previous result beat still waits in the output register.
// Reset (aresetn low, synchronous) empties the table and drops any pending result beat.
`default_nettype none
module sparse_polynomial_term_table
    import spt_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [31:0] coefficient, [39:32] exponent
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // [1:0] cmd
    input  wire logic [1:0]            s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [31:0] read_coefficient, [32] found, [34:33] status, [43:35] degree,
    // [48:44] term_count, [49] saturated, [55:50] zero
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_INSERT,
        ST_DONE
    } state_t;

    state_t            state_reg;
    cmd_t              cmd_reg;
    logic [COEF_W-1:0] coef_reg;
    logic [EXP_W-1:0]  exp_reg;
    logic [IDX_W-1:0]  step_reg;
    logic              found_reg;
    logic              sat_reg;
    logic              placed_reg;
    logic [COEF_W-1:0] rd_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              deg_any_reg;
    logic [EXP_W-1:0]  deg_max_reg;
    status_t           status_reg;
    logic              m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    entry_t    cell_q [MAX_TERMS];
    entry_t    head_out;
    head_ctl_t head_ctl;
    head_res_t head_res;
    logic      shift_en;
    logic      last_step;
    logic      need_insert;
    logic      out_free;
    logic [DEG_W-1:0] degree;

    assign shift_en  = (state_reg == ST_SCAN) || (state_reg == ST_INSERT);
    assign last_step = step_reg == IDX_W'(MAX_TERMS - 1);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign need_insert = (cmd_reg == CMD_ADD) && !(found_reg || head_res.match)
                         && (coef_reg != '0);

    assign head_ctl = '{cmd: cmd_reg, insert: state_reg == ST_INSERT, placed: placed_reg,
                        coef: coef_reg, exp: exp_reg};

    spt_head u_head (
        .ctl  (head_ctl),
        .din  (cell_q[0]),
        .dout (head_out),
        .res  (head_res)
    );

    // Cell 0 feeds the head; the processed entry re-enters at the far end.
    for (genvar i = 0; i < MAX_TERMS; i++) begin : g_cell
        if (i == MAX_TERMS - 1) begin : g_tail
            spt_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (shift_en),
                .din      (head_out),
                .dout     (cell_q[i])
            );
        end else begin : g_mid
            spt_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (shift_en),
                .din      (cell_q[i+1]),
                .dout     (cell_q[i])
            );
        end
    end

    assign degree = deg_any_reg ? {1'b0, deg_max_reg} : {DEG_W{1'b1}};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            step_reg     <= '0;
            placed_reg   <= 1'b0;
            cnt_reg      <= '0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg     <= cmd_t'(s_tuser);
                        coef_reg    <= s_tdata[COEF_W-1:0];
                        exp_reg     <= s_tdata[COEF_W+EXP_W-1:COEF_W];
                        step_reg    <= '0;
                        found_reg   <= 1'b0;
                        sat_reg     <= 1'b0;
                        placed_reg  <= 1'b0;
                        rd_reg      <= '0;
                        cnt_reg     <= '0;
                        deg_any_reg <= 1'b0;
                        deg_max_reg <= '0;
                        status_reg  <= STAT_OK;
                        state_reg   <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    step_reg  <= step_reg + 1'b1;
                    found_reg <= found_reg || head_res.match;
                    sat_reg   <= sat_reg || head_res.sat;
                    if (head_res.match && cmd_reg == CMD_READ) begin
                        rd_reg <= cell_q[0].coef;
                    end
                    if (head_out.valid) begin
                        cnt_reg     <= cnt_reg + 1'b1;
                        deg_any_reg <= 1'b1;
                        if (!deg_any_reg || head_out.exp > deg_max_reg) begin
                            deg_max_reg <= head_out.exp;
                        end
                    end
                    if (last_step) begin
                        step_reg <= '0;
                        if (cmd_reg == CMD_SET && !(found_reg || head_res.match)) begin
                            status_reg <= STAT_MISSING;
                            state_reg  <= ST_DONE;
                        end else if (need_insert) begin
                            // With the last entry added, the count holds every entry, so full means no free cell.
                            if ((cnt_reg + CNT_W'(head_out.valid)) == CNT_W'(MAX_TERMS)) begin
                                status_reg <= STAT_FULL;
                                state_reg  <= ST_DONE;
                            end else begin
                                state_reg <= ST_INSERT;
                            end
                        end else begin
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_INSERT: begin
                    step_reg <= step_reg + 1'b1;
                    if (head_res.place) begin
                        placed_reg  <= 1'b1;
                        cnt_reg     <= cnt_reg + 1'b1;
                        deg_any_reg <= 1'b1;
                        if (!deg_any_reg || exp_reg > deg_max_reg) begin
                            deg_max_reg <= exp_reg;
                        end
                    end
                    if (last_step) begin
                        step_reg  <= '0;
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {{(OUT_DATA_W-50){1'b0}}, sat_reg,
                                         cnt_reg[TCNT_W-1:0], degree, status_reg,
                                         found_reg, rd_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_TERMS))
        else $error("term count exceeds table depth");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a command is in progress");

    a_insert_only_absent: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_INSERT |-> !found_reg && cmd_reg == CMD_ADD)
        else $error("append pass for a present exponent or non-add command");

    a_single_place: assert property (@(posedge aclk) disable iff (!aresetn)
        placed_reg && state_reg == ST_INSERT |-> !head_res.place)
        else $error("new term placed twice");
`endif

endmodule
`default_nettype wire

### test/spt_term_table_checker.sv
// Checker for the term table: predicts every result beat and compares it with the block's output.
module spt_term_table_checker
    import spt_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    // [31:0] coefficient, [39:32] exponent
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // [1:0] cmd
    input  wire logic [1:0]            s_tuser,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    // [31:0] read_coefficient, [32] found, [34:33] status, [43:35] degree,
    // [48:44] term_count, [49] saturated
    input  wire logic [OUT_DATA_W-1:0] m_tdata,
    output int                         failures,
    output int                         outstanding
);

    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;

    typedef struct {
        logic [COEF_W-1:0] read_coef;
        logic              found;
        status_t           status;
        logic [DEG_W-1:0]  degree;
        logic [TCNT_W-1:0] term_count;
        logic              saturated;
    } term_report_t;

    // Shadow copy of the table, kept packed with new terms appended at the end.
    logic signed [COEF_W-1:0] coef_table [MAX_TERMS];
    logic [EXP_W-1:0]         exp_table  [MAX_TERMS];
    int                       terms_held;
    term_report_t             expected_reports [$];

    function automatic longint clamp_word(input longint value);
        if (value > WORD_MAX) return WORD_MAX;
        if (value < WORD_MIN) return WORD_MIN;
        return value;
    endfunction

    // Removing a term shifts every later entry down by one place.
    function automatic void drop_term(input int pos);
        for (int k = pos; k + 1 < terms_held; k++) begin
            coef_table[k] = coef_table[k + 1];
            exp_table[k]  = exp_table[k + 1];
        end
        terms_held--;
    endfunction

    function automatic term_report_t apply_command(input cmd_t cmd,
                                                   input logic signed [COEF_W-1:0] coef,
                                                   input logic [EXP_W-1:0] exponent);
        term_report_t report;
        int           pos;
        int           i;
        int           top_exp;
        longint       sum;
        report.read_coef = '0;
        report.found     = 1'b0;
        report.status    = STAT_OK;
        report.saturated = 1'b0;
        pos = terms_held;
        for (i = 0; i < terms_held && pos == terms_held; i++) begin
            if (exp_table[i] == exponent) pos = i;
        end
        if (cmd == CMD_DIFF) begin
            i = 0;
            while (i < terms_held) begin
                if (exp_table[i] == '0) begin
                    drop_term(i);
                end else begin
                    sum = longint'(coef_table[i]) * longint'(exp_table[i]);
                    if (clamp_word(sum) != sum) report.saturated = 1'b1;
                    coef_table[i] = COEF_W'(clamp_word(sum));
                    exp_table[i]  = exp_table[i] - 8'd1;
                    i++;
                end
            end
        end else if (pos < terms_held) begin
            report.found = 1'b1;
            case (cmd)
                CMD_ADD: begin
                    sum = longint'(coef_table[pos]) + longint'(coef);
                    if (clamp_word(sum) != sum) report.saturated = 1'b1;
                    coef_table[pos] = COEF_W'(clamp_word(sum));
                    if (coef_table[pos] == 0) drop_term(pos);
                end
                CMD_SET: begin
                    coef_table[pos] = coef;
                    if (coef == 0) drop_term(pos);
                end
                default: begin
                    report.read_coef = coef_table[pos];
                end
            endcase
        end else if (cmd == CMD_ADD) begin
            // A zero added to an absent exponent leaves the table alone.
            if (coef != 0) begin
                if (terms_held < MAX_TERMS) begin
                    coef_table[terms_held] = coef;
                    exp_table[terms_held]  = exponent;
                    terms_held++;
                end else begin
                    report.status = STAT_FULL;
                end
            end
        end else if (cmd == CMD_SET) begin
            report.status = STAT_MISSING;
        end
        top_exp = -1;
        for (i = 0; i < terms_held; i++) begin
            if (int'(exp_table[i]) > top_exp) top_exp = int'(exp_table[i]);
        end
        report.degree     = DEG_W'(top_exp);
        report.term_count = TCNT_W'(terms_held);
        return report;
    endfunction

    function automatic int field_mismatch(input string field, input longint want,
                                          input longint got);
        if (want == got) return 0;
        $error("%s mismatch: expected %0d, got %0d", field, want, got);
        return 1;
    endfunction

    always @(posedge aclk) begin : watch
        term_report_t want;
        if (!aresetn) begin
            terms_held = 0;
            failures   = 0;
            expected_reports.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_reports.size() == 0) begin
                    $error("result beat arrived with no command pending");
                    failures++;
                end else begin
                    want = expected_reports.pop_front();
                    failures += field_mismatch("read_coefficient",
                        longint'($signed(want.read_coef)), longint'($signed(m_tdata[31:0])));
                    failures += field_mismatch("found", want.found, m_tdata[32]);
                    failures += field_mismatch("status", want.status, m_tdata[34:33]);
                    failures += field_mismatch("degree",
                        longint'($signed(want.degree)), longint'($signed(m_tdata[43:35])));
                    failures += field_mismatch("term_count", want.term_count, m_tdata[48:44]);
                    failures += field_mismatch("saturated", want.saturated, m_tdata[49]);
                end
            end
            if (s_tvalid && s_tready) begin
                expected_reports.push_back(apply_command(cmd_t'(s_tuser), s_tdata[31:0],
                                                         s_tdata[39:32]));
            end
        end
        outstanding = expected_reports.size();
    end

endmodule

### test/sparse_polynomial_term_table_tb.sv
// Testbench top: drives commands into the term table, drains results and reports the verdict.
module sparse_polynomial_term_table_tb;
    import spt_pkg::*;

    localparam int RANDOM_COMMANDS = 600;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 2 * MAX_TERMS + 10;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    int                    failures;
    int                    outstanding;
    int                    cycle_count;
    bit                    idle_allowed;

    sparse_polynomial_term_table u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    spt_term_table_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .failures    (failures),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Offers one command beat and returns at the falling edge after it is taken.
    task automatic send_command(input cmd_t cmd, input logic [COEF_W-1:0] coef,
                                input logic [EXP_W-1:0] exponent);
        int gap;
        gap = idle_allowed ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {exponent, coef};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Result side: random stalls, a stretch without stalls, and one long hold-off
    // that lets the block fill up and push back on its input.
    initial begin
        int stall;
        int results_taken;
        bit held_off;
        m_tready      = 1'b0;
        results_taken = 0;
        held_off      = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = ((results_taken / 50) % 3 == 1) ? 0 : $urandom_range(0, 8);
            if (results_taken == 200 && !held_off) begin
                held_off = 1'b1;
                stall    = 400;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            results_taken++;
            @(negedge aclk);
        end
    end

    initial begin
        int          i;
        int          pick;
        cmd_t        cmd;
        logic [31:0] coef;
        logic [7:0]  exponent;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = CMD_ADD;
        idle_allowed = 1'b1;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // Empty table: read, set of a missing exponent, zero add, differentiate.
        send_command(CMD_READ, '0, 8'd0);
        send_command(CMD_SET, 32'd5, 8'd3);
        send_command(CMD_ADD, '0, 8'd7);
        send_command(CMD_DIFF, '0, 8'd0);
        // Fill the table to capacity, then try one more append.
        send_command(CMD_ADD, 32'h7FFF_FFFF, 8'd255);
        send_command(CMD_ADD, 32'h8000_0000, 8'd0);
        for (i = 1; i <= MAX_TERMS - 2; i++) send_command(CMD_ADD, 32'(i * 37 + 1), 8'(i));
        send_command(CMD_ADD, 32'd9, 8'd200);
        // Saturation at both ends, reads, removal by set and by add.
        send_command(CMD_ADD, 32'd1, 8'd255);
        send_command(CMD_ADD, 32'hFFFF_FFFF, 8'd0);
        send_command(CMD_READ, '0, 8'd255);
        send_command(CMD_READ, '0, 8'd0);
        send_command(CMD_SET, 32'd0, 8'd3);
        send_command(CMD_ADD, 32'(-186), 8'd5);
        send_command(CMD_DIFF, '0, 8'd0);

        for (i = 0; i < RANDOM_COMMANDS; i++) begin
            idle_allowed = ((i / 40) % 3 != 2);
            pick = $urandom_range(0, 99);
            if (pick < 45) cmd = CMD_ADD;
            else if (pick < 60) cmd = CMD_SET;
            else if (pick < 70) cmd = CMD_DIFF;
            else cmd = CMD_READ;
            // Mostly a small pool of exponents so commands hit existing terms.
            exponent = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 20)) : 8'($urandom());
            pick = $urandom_range(0, 9);
            if (pick < 5) coef = 32'(int'($urandom_range(0, 200)) - 100);
            else if (pick < 7) coef = $urandom();
            else if (pick == 7) coef = 32'h7FFF_FFFF;
            else if (pick == 8) coef = 32'h8000_0000;
            else coef = '0;
            send_command(cmd, coef, exponent);
        end
        s_tvalid <= 1'b0;

        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (failures == 0 && outstanding == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### sparse_polynomial_term_table.f
hw/rtl/spt_pkg.sv
hw/rtl/spt_cell.sv
hw/rtl/spt_head.sv
hw/rtl/sparse_polynomial_term_table.sv
test/spt_term_table_checker.sv
test/sparse_polynomial_term_table_tb.sv
